// ----- rtl/reversible_prime_check_top_assert.svh -----
// Assertion macros for the reversible prime check block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef REVERSIBLE_PRIME_CHECK_TOP_ASSERT_SVH
`define REVERSIBLE_PRIME_CHECK_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rpc_pkg.sv -----
// Shared widths and types for the reversible prime check block.
// No dependencies; used by rpc_div and the top level.
package rpc_pkg;

  localparam int VALUE_BITS = 17;
  localparam int RADIX_BITS = 4;
  // A radix below 16 grows the reversal by at most RADIX_BITS bits.
  localparam int REV_BITS   = VALUE_BITS + RADIX_BITS;
  // Trial divisors stay near the square root of the widest value.
  localparam int DIV_BITS   = REV_BITS / 2 + 1;
  localparam int SQ_BITS    = 2 * DIV_BITS;
  localparam int CNT_BITS   = $clog2(REV_BITS);

  localparam logic [RADIX_BITS-1:0] MIN_RADIX = RADIX_BITS'(2);
  localparam logic [DIV_BITS-1:0]   FIRST_DIV = DIV_BITS'(2);
  localparam logic [SQ_BITS-1:0]    FIRST_SQ  = SQ_BITS'(4);

  typedef struct packed {
    logic                start;
    logic [REV_BITS-1:0] dividend;
    logic [DIV_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [REV_BITS-1:0] quotient;
    logic [DIV_BITS-1:0] remainder;
  } div_rsp_t;

endpackage

// ----- rtl/rpc_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on rpc_pkg for widths and the request/response structs.
module rpc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rpc_pkg::div_req_t req,
  output rpc_pkg::div_rsp_t rsp
);

  logic [rpc_pkg::REV_BITS-1:0] q_r, q_nxt;
  logic [rpc_pkg::DIV_BITS-1:0] rem_r, rem_nxt;
  logic [rpc_pkg::DIV_BITS-1:0] dsr_r;
  logic [rpc_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [rpc_pkg::DIV_BITS:0]   shifted;
  logic                         ge;

  assign shifted = {rem_r, q_r[rpc_pkg::REV_BITS-1]};
  assign ge      = (shifted >= {1'b0, dsr_r});

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? rpc_pkg::DIV_BITS'(shifted - {1'b0, dsr_r})
                   : shifted[rpc_pkg::DIV_BITS-1:0];
      q_nxt   = {q_r[rpc_pkg::REV_BITS-2:0], ge};
      if (cnt_r == rpc_pkg::CNT_BITS'(rpc_pkg::REV_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + rpc_pkg::CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      dsr_r <= req.divisor;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = q_r;
  assign rsp.remainder = rem_r;

endmodule

// ----- rtl/reversible_prime_check_top.sv -----
// Reversible prime check: digit reversal in a radix plus two trial-division primality tests.
// Depends on rpc_pkg and instantiates the serial divider rpc_div.
//
// Each input word carries a number and a radix; a radix of 0 or 1 is taken as 2, and radices
// up to 15 are honored. The block reverses the number's digits in that radix, tests the number
// for primality by trial division, and, only if the number is prime, tests the reversed value
// the same way. One output word follows each input word, in order. Every step runs on a single
// bit-serial divider. Digit reversal costs one division per digit, and each trial divisor costs
// one division and no more, since the check of the divisor squared against the value shares
// the cycle that starts the division. Trial division stops once the divisor squared exceeds the
// value or a divisor leaves no remainder. The number stays below 2^17 and needs at most
// about 361 divisors; its reversal stays below a million in every radix up to 15 and needs
// at most about 999. The fastest item is zero; the slowest is a prime near the top of the
// number range whose base-ten reversal is a prime near a million. in_stall stays high from
// the cycle after a word is accepted until its result is placed in the output register; that
// register holds a finished result while the next word is already taken.
module reversible_prime_check_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rpc_pkg::VALUE_BITS-1:0]   in_number,
  input  logic [rpc_pkg::RADIX_BITS-1:0]   in_radix,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_both_prime,
  output logic                             out_number_prime,
  output logic [rpc_pkg::REV_BITS-1:0]     out_reversed_value
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_REV      = 3'd1;
  localparam logic [2:0] S_REV_WAIT = 3'd2;
  localparam logic [2:0] S_PINIT    = 3'd3;
  localparam logic [2:0] S_PCHK     = 3'd4;
  localparam logic [2:0] S_PWAIT    = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]                       state_r, state_nxt;
  logic [rpc_pkg::VALUE_BITS-1:0]   n_r, n_nxt;
  logic [rpc_pkg::VALUE_BITS-1:0]   v_r, v_nxt;
  logic [rpc_pkg::RADIX_BITS-1:0]   base_r, base_nxt;
  logic [rpc_pkg::REV_BITS-1:0]     acc_r, acc_nxt;
  logic [rpc_pkg::REV_BITS-1:0]     t_r, t_nxt;
  logic [rpc_pkg::DIV_BITS-1:0]     d_r, d_nxt;
  logic [rpc_pkg::SQ_BITS-1:0]      sq_r, sq_nxt;
  logic                             phase_r, phase_nxt;
  logic                             np_r, np_nxt;
  logic                             rp_r, rp_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_both_r, out_both_nxt;
  logic                             out_np_r, out_np_nxt;
  logic [rpc_pkg::REV_BITS-1:0]     out_rev_r, out_rev_nxt;

  rpc_pkg::div_req_t                div_req;
  rpc_pkg::div_rsp_t                div_rsp;

  logic                             in_take;
  logic                             out_free;
  logic [rpc_pkg::REV_BITS-1:0]     t_sel;
  logic                             sq_over;
  logic [rpc_pkg::REV_BITS+rpc_pkg::RADIX_BITS-1:0] acc_prod;
  logic                             verdict_en;
  logic                             verdict;

  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // The value under test: the number first, then its reversal.
  assign t_sel    = phase_r ? acc_r : {{rpc_pkg::RADIX_BITS{1'b0}}, n_r};
  assign sq_over  = (sq_r > {{(rpc_pkg::SQ_BITS-rpc_pkg::REV_BITS){1'b0}}, t_r});
  assign acc_prod = acc_r * base_r;

  // One divider serves both the digit peeling and the trial divisions.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = t_r;
    div_req.divisor  = d_r;
    if (state_r == S_REV) begin
      div_req.start    = (v_r != '0);
      div_req.dividend = {{rpc_pkg::RADIX_BITS{1'b0}}, v_r};
      div_req.divisor  = {{(rpc_pkg::DIV_BITS-rpc_pkg::RADIX_BITS){1'b0}}, base_r};
    end else if (state_r == S_PCHK) begin
      div_req.start = !sq_over;
    end
  end

  rpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // A primality verdict can come from three places: a value below two, the divisor passing
  // the square root, or a divisor that leaves no remainder.
  always_comb begin
    verdict_en = 1'b0;
    verdict    = 1'b0;
    case (state_r)
      S_PINIT: begin
        if (t_sel < rpc_pkg::REV_BITS'(2)) begin
          verdict_en = 1'b1;
        end
      end
      S_PCHK: begin
        if (sq_over) begin
          verdict_en = 1'b1;
          verdict    = 1'b1;
        end
      end
      S_PWAIT: begin
        if (div_rsp.done && (div_rsp.remainder == '0)) begin
          verdict_en = 1'b1;
        end
      end
      default: begin
        verdict_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    v_nxt         = v_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    t_nxt         = t_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    phase_nxt     = phase_r;
    np_nxt        = np_r;
    rp_nxt        = rp_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_both_nxt  = out_both_r;
    out_np_nxt    = out_np_r;
    out_rev_nxt   = out_rev_r;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          n_nxt     = in_number;
          v_nxt     = in_number;
          base_nxt  = (in_radix < rpc_pkg::MIN_RADIX) ? rpc_pkg::MIN_RADIX : in_radix;
          acc_nxt   = '0;
          phase_nxt = 1'b0;
          state_nxt = S_REV;
        end
      end
      S_REV: begin
        // Zero has no digits left: the reversal is complete.
        state_nxt = (v_r == '0) ? S_PINIT : S_REV_WAIT;
      end
      S_REV_WAIT: begin
        if (div_rsp.done) begin
          acc_nxt   = acc_prod[rpc_pkg::REV_BITS-1:0] +
                      {{(rpc_pkg::REV_BITS-rpc_pkg::DIV_BITS){1'b0}}, div_rsp.remainder};
          v_nxt     = div_rsp.quotient[rpc_pkg::VALUE_BITS-1:0];
          state_nxt = S_REV;
        end
      end
      S_PINIT: begin
        t_nxt  = t_sel;
        d_nxt  = rpc_pkg::FIRST_DIV;
        sq_nxt = rpc_pkg::FIRST_SQ;
        if (!verdict_en) begin
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        if (!sq_over) begin
          state_nxt = S_PWAIT;
        end
      end
      S_PWAIT: begin
        if (div_rsp.done && !verdict_en) begin
          // (d+1)^2 = d^2 + 2d + 1
          d_nxt     = d_r + rpc_pkg::DIV_BITS'(1);
          sq_nxt    = sq_r + rpc_pkg::SQ_BITS'({d_r, 1'b1});
          state_nxt = S_PCHK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_both_nxt  = np_r && rp_r;
          out_np_nxt    = np_r;
          out_rev_nxt   = acc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // The reversal is only tested when the number itself is prime.
    if (verdict_en) begin
      if (!phase_r) begin
        np_nxt = verdict;
        if (verdict) begin
          phase_nxt = 1'b1;
          state_nxt = S_PINIT;
        end else begin
          rp_nxt    = 1'b0;
          state_nxt = S_DONE;
        end
      end else begin
        rp_nxt    = verdict;
        state_nxt = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    v_r        <= v_nxt;
    base_r     <= base_nxt;
    acc_r      <= acc_nxt;
    t_r        <= t_nxt;
    d_r        <= d_nxt;
    sq_r       <= sq_nxt;
    phase_r    <= phase_nxt;
    np_r       <= np_nxt;
    rp_r       <= rp_nxt;
    out_both_r <= out_both_nxt;
    out_np_r   <= out_np_nxt;
    out_rev_r  <= out_rev_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_both_prime     = out_both_r;
  assign out_number_prime   = out_np_r;
  assign out_reversed_value = out_rev_r;

endmodule

// ----- rtl/rpc_checker.sv -----
// Port-level checker for reversible_prime_check_top, attached by bind.
// Depends on rpc_pkg and the assertion macros header.
`include "reversible_prime_check_top_assert.svh"

module rpc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             out_both_prime,
  input logic                             out_number_prime,
  input logic [rpc_pkg::REV_BITS-1:0]     out_reversed_value
);

  // A held result word keeps its contents.
  `RPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_reversed_value) && $stable(out_number_prime) && $stable(out_both_prime), "output word changed while stalled")

  // An accepted word keeps the block busy on the following cycle.
  `RPC_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input taken again right after a word")

  // Both prime implies the number is prime.
  `RPC_ASSERT_SAME(a_both_implies_num, out_valid && out_both_prime, out_number_prime, "both_prime without number_prime")

  // A prime reversal is two or odd.
  `RPC_ASSERT_SAME(a_rev_prime_odd, out_valid && out_both_prime, out_reversed_value[0] || (out_reversed_value == 2), "even reversal reported prime")

endmodule

bind reversible_prime_check_top rpc_checker u_rpc_checker (.*);

// ----- test/reversible_prime_check_top_tb.sv -----
// Testbench for reversible_prime_check_top: digit reversal in a radix plus primality checks.
// Depends on rpc_pkg and the RTL; a scoreboard class predicts every output word.
`timescale 1ns / 100ps

class prime_scoreboard;
  typedef struct packed {
    logic                         both_prime;
    logic                         number_prime;
    logic [rpc_pkg::REV_BITS-1:0] reversed_value;
  } verdict_t;

  verdict_t verdict_q[$];
  int       errors = 0;

  function longint unsigned reverse_digits(longint unsigned v, longint unsigned base);
    longint unsigned acc;
    acc = 0;
    while (v != 0) begin
      acc = acc * base + (v % base);
      v = v / base;
    end
    return acc;
  endfunction

  function bit trial_prime(longint unsigned v);
    longint unsigned d;
    if (v < 2) return 1'b0;
    for (d = 2; d * d <= v; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Works out the verdict for one accepted input word and queues it.
  function void note_word(logic [rpc_pkg::VALUE_BITS-1:0] number,
                          logic [rpc_pkg::RADIX_BITS-1:0] radix);
    longint unsigned base;
    longint unsigned rev;
    bit              n_ok;
    bit              r_ok;
    verdict_t        v;
    base = (radix < rpc_pkg::MIN_RADIX) ? 2 : longint'(radix);
    rev  = reverse_digits(longint'(number), base);
    n_ok = trial_prime(longint'(number));
    r_ok = n_ok ? trial_prime(rev) : 1'b0;
    v.both_prime     = n_ok && r_ok;
    v.number_prime   = n_ok;
    v.reversed_value = rev[rpc_pkg::REV_BITS-1:0];
    verdict_q.insert(verdict_q.size(), v);
  endfunction

  // Compares one accepted output word with the oldest queued verdict.
  function void check_word(logic both_prime, logic number_prime,
                           logic [rpc_pkg::REV_BITS-1:0] reversed_value);
    verdict_t v;
    if (verdict_q.size() == 0) begin
      $error("output word with no input word waiting");
      errors++;
      return;
    end
    v = verdict_q.pop_front();
    if (both_prime !== v.both_prime) begin
      $error("both_prime: expected %0d, actual %0d", v.both_prime, both_prime);
      errors++;
    end
    if (number_prime !== v.number_prime) begin
      $error("number_prime: expected %0d, actual %0d", v.number_prime, number_prime);
      errors++;
    end
    if (reversed_value !== v.reversed_value) begin
      $error("reversed_value: expected %0d, actual %0d", v.reversed_value, reversed_value);
      errors++;
    end
  endfunction

  function int outstanding();
    return verdict_q.size();
  endfunction
endclass

module reversible_prime_check_top_tb;

  // The slowest word is a prime near the top of the number range whose base-ten reversal is
  // also prime and near a million. The watchdog allows many times the slowest word.
  localparam int WATCHDOG_LIMIT = 250000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int RANDOM_WORDS   = 100;
  // The receiver holds off this long once, so the block fills up and stalls its input.
  localparam int HOLD_CYCLES    = 2000;
  localparam int HOLD_AT_RESULT = 8;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [rpc_pkg::VALUE_BITS-1:0] in_number = '0;
  logic [rpc_pkg::RADIX_BITS-1:0] in_radix = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_both_prime;
  logic                           out_number_prime;
  logic [rpc_pkg::REV_BITS-1:0]   out_reversed_value;

  prime_scoreboard verdicts = new();

  int words_sent   = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  reversible_prime_check_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_number          (in_number),
    .in_radix           (in_radix),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_both_prime     (out_both_prime),
    .out_number_prime   (out_number_prime),
    .out_reversed_value (out_reversed_value)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sender side. Called just after a rising edge. It may idle at random first, then offers
  // the word and holds it unchanged until the block takes it. Exactly one nonblocking write
  // of in_valid happens per time step, so a back-to-back word never glitches valid low.
  // Words 40 to 64 of the random part go out with no idling at all.
  task automatic send_word(input logic [rpc_pkg::VALUE_BITS-1:0] number,
                           input logic [rpc_pkg::RADIX_BITS-1:0] radix);
    bit eager;
    eager = (words_sent >= 40 + 25) && (words_sent < 65 + 25);
    while (!eager && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= number;
    in_radix  <= radix;
    do @(posedge clk); while (in_stall);
    verdicts.note_word(number, radix);
    words_sent++;
  endtask

  // Random word: mostly small numbers so that trial division stays short, the rest anywhere
  // in the 17-bit range so that every bit of the field toggles. The radix is usually a
  // meaningful base, sometimes any 4-bit value including 0, 1 and 11 to 15.
  task automatic send_random_word();
    logic [rpc_pkg::VALUE_BITS-1:0] number;
    logic [rpc_pkg::RADIX_BITS-1:0] radix;
    if ($urandom_range(99) < 55) number = rpc_pkg::VALUE_BITS'($urandom_range(1023));
    else number = rpc_pkg::VALUE_BITS'($urandom);
    if ($urandom_range(99) < 80) radix = rpc_pkg::RADIX_BITS'($urandom_range(10, 2));
    else radix = rpc_pkg::RADIX_BITS'($urandom_range(15));
    send_word(number, radix);
  endtask

  // Receiver side. An output word is taken at an edge where out_valid is high and out_stall
  // is low; the values are sampled before that edge's updates land. The receiver stalls in
  // about a quarter of the cycles, not at all while 45 to 69 results have been taken, and once
  // holds off for a long stretch that it counts itself while the sender keeps pushing words in.
  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        verdicts.check_word(out_both_prime, out_number_prime, out_reversed_value);
        results_seen++;
      end
      if (!hold_done && results_seen == HOLD_AT_RESULT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (results_seen >= 45 && results_seen < 70) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 25);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int i;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: zero and one, the smallest primes, the top of the number range in
    // several bases, reversals that are prime or not, palindromes, trailing zeros that
    // vanish on reversal, radix 0 and 1 taken as base 2, and radices above ten.
    send_word(rpc_pkg::VALUE_BITS'(0), rpc_pkg::RADIX_BITS'(10));
    send_word(rpc_pkg::VALUE_BITS'(1), rpc_pkg::RADIX_BITS'(10));
    send_word(rpc_pkg::VALUE_BITS'(2), rpc_pkg::RADIX_BITS'(2));
    send_word(rpc_pkg::VALUE_BITS'(2), rpc_pkg::RADIX_BITS'(10));
    send_word(rpc_pkg::VALUE_BITS'(3), rpc_pkg::RADIX_BITS'(2));
    send_word(rpc_pkg::VALUE_BITS'(4), rpc_pkg::RADIX_BITS'(2));
    send_word(rpc_pkg::VALUE_BITS'(13), rpc_pkg::RADIX_BITS'(10));
    send_word(rpc_pkg::VALUE_BITS'(23), rpc_pkg::RADIX_BITS'(10));
    send_word(rpc_pkg::VALUE_BITS'(97), rpc_pkg::RADIX_BITS'(10));
    send_word(rpc_pkg::VALUE_BITS'(101), rpc_pkg::RADIX_BITS'(10));
    send_word(rpc_pkg::VALUE_BITS'(10), rpc_pkg::RADIX_BITS'(10));
    send_word(rpc_pkg::VALUE_BITS'(13), rpc_pkg::RADIX_BITS'(0));
    send_word(rpc_pkg::VALUE_BITS'(11), rpc_pkg::RADIX_BITS'(1));
    send_word(rpc_pkg::VALUE_BITS'(1021), rpc_pkg::RADIX_BITS'(2));
    send_word(rpc_pkg::VALUE_BITS'(65536), rpc_pkg::RADIX_BITS'(2));
    send_word(rpc_pkg::VALUE_BITS'(131070), rpc_pkg::RADIX_BITS'(10));
    send_word(rpc_pkg::VALUE_BITS'(131071), rpc_pkg::RADIX_BITS'(2));
    send_word(rpc_pkg::VALUE_BITS'(131071), rpc_pkg::RADIX_BITS'(10));
    send_word(rpc_pkg::VALUE_BITS'(131071), rpc_pkg::RADIX_BITS'(15));
    send_word(rpc_pkg::VALUE_BITS'(131071), rpc_pkg::RADIX_BITS'(0));
    send_word(rpc_pkg::VALUE_BITS'(37), rpc_pkg::RADIX_BITS'(11));
    send_word(rpc_pkg::VALUE_BITS'(211), rpc_pkg::RADIX_BITS'(12));
    send_word(rpc_pkg::VALUE_BITS'(61), rpc_pkg::RADIX_BITS'(13));
    send_word(rpc_pkg::VALUE_BITS'(113), rpc_pkg::RADIX_BITS'(14));
    send_word(rpc_pkg::VALUE_BITS'(0), rpc_pkg::RADIX_BITS'(15));

    for (i = 0; i < RANDOM_WORDS; i++) send_random_word();
    in_valid <= 1'b0;

    // Let every pending output word arrive, then give the block time to show anything extra.
    while (verdicts.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (verdicts.outstanding() != 0) begin
      $error("%0d expected output words never arrived", verdicts.outstanding());
      verdicts.errors++;
    end
    if (verdicts.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
